[rtl/sapt_pkg.sv]
package sapt_pkg;

    // counter width and count of tally cells
    localparam int COUNT_WIDTH = 32;
    localparam int TALLY_CELLS = 9;
    localparam int CELL_W      = 4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item modes
    localparam logic [2:0] MODE_SITE_BEGIN = 3'd0;
    localparam logic [2:0] MODE_READ_BEGIN = 3'd1;
    localparam logic [2:0] MODE_CIGAR_OP   = 3'd2;
    localparam logic [2:0] MODE_READ_BASE  = 3'd3;
    localparam logic [2:0] MODE_SITE_END   = 3'd4;
    localparam logic [2:0] MODE_QUERY      = 3'd5;

    // cigar op codes
    localparam logic [3:0] CIGAR_M = 4'd0;
    localparam logic [3:0] CIGAR_I = 4'd1;
    localparam logic [3:0] CIGAR_D = 4'd2;
    localparam logic [3:0] CIGAR_N = 4'd3;
    localparam logic [3:0] CIGAR_S = 4'd4;
    localparam logic [3:0] CIGAR_EQ = 4'd7;
    localparam logic [3:0] CIGAR_X = 4'd8;

    // flag bit of a reverse-strand read
    localparam int FLAG_REVERSE_BIT = 4;

    // register indexes
    localparam logic REG_MIN_MAPQ    = 1'b0;
    localparam logic REG_REJECT_MASK = 1'b1;

    localparam logic [7:0]  MIN_MAPQ_RESET    = 8'd20;
    localparam logic [15:0] REJECT_MASK_RESET = 16'h0704;

    // work handed to the back part
    typedef enum logic [1:0] {
        OP_PASS,
        OP_INCR,
        OP_QUERY
    } back_op_t;

    typedef struct packed {
        back_op_t          op;
        logic              base_needed;
        logic [31:0]       base_offset;
        logic              read_kept;
        logic              site_counted;
        logic [CELL_W-1:0] tally_sel;
    } queue_entry_t;

    typedef struct packed {
        logic [7:0]  min_map_quality;
        logic [15:0] reject_flag_mask;
    } cfg_t;

    // 4-bit nucleotide code to ascii
    function automatic logic [7:0] nt16_ascii(input logic [3:0] code);
        logic [7:0] ch;
        unique case (code)
            4'd0:  ch = "=";
            4'd1:  ch = "A";
            4'd2:  ch = "C";
            4'd3:  ch = "M";
            4'd4:  ch = "G";
            4'd5:  ch = "R";
            4'd6:  ch = "S";
            4'd7:  ch = "V";
            4'd8:  ch = "T";
            4'd9:  ch = "W";
            4'd10: ch = "Y";
            4'd11: ch = "H";
            4'd12: ch = "K";
            4'd13: ch = "D";
            4'd14: ch = "B";
            default: ch = "N";
        endcase
        return ch;
    endfunction

endpackage

[rtl/sapt_front.sv]
module sapt_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sapt_pkg::cfg_t        cfg,
    input  logic                  s_valid,
    input  logic                  queue_full,
    output logic                  s_ready,
    input  logic [2:0]            s_mode,
    input  logic [30:0]           s_position,
    input  logic [7:0]            s_ref_letter,
    input  logic [7:0]            s_alt_letter,
    input  logic [15:0]           s_read_flags,
    input  logic [7:0]            s_map_quality,
    input  logic [3:0]            s_cigar_code,
    input  logic [27:0]           s_cigar_length,
    input  logic [3:0]            s_base_code,
    input  logic [3:0]            s_cell_index,
    output logic                  push,
    output sapt_pkg::queue_entry_t push_entry
);

    logic [30:0] site_position_reg, site_position_next;
    logic [7:0]  site_ref_reg, site_ref_next;
    logic [7:0]  site_alt_reg, site_alt_next;
    logic        read_ok_reg, read_ok_next;
    logic        read_reverse_reg, read_reverse_next;
    logic [31:0] walk_ref_reg, walk_ref_next;
    logic [31:0] walk_query_reg, walk_query_next;
    logic        site_found_reg, site_found_next;
    logic        walk_over_reg, walk_over_next;
    logic [1:0]  kept_reg, kept_next;
    logic [1:0]  pair_strand_reg, pair_strand_next;
    logic [1:0]  pair_allele_reg, pair_allele_next;

    logic        accept;
    logic [31:0] site32;
    logic [31:0] len32;
    logic [32:0] ref_end;
    logic        is_match;
    logic        hit;
    logic [31:0] hit_offset;
    logic [7:0]  base_ch;
    logic        is_ref;
    logic        is_alt;
    logic [1:0]  row;
    logic [1:0]  col;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept;

    // closed-form walk of one cigar op
    assign site32     = {1'b0, site_position_reg};
    assign len32      = {4'b0, s_cigar_length};
    assign ref_end    = {1'b0, walk_ref_reg} + {1'b0, len32};
    assign is_match   = (s_cigar_code == sapt_pkg::CIGAR_M) ||
                        (s_cigar_code == sapt_pkg::CIGAR_EQ) ||
                        (s_cigar_code == sapt_pkg::CIGAR_X);
    assign hit        = (walk_ref_reg <= site32) && ({1'b0, site32} < ref_end);
    assign hit_offset = walk_query_reg + (site32 - walk_ref_reg);

    // allele of the read base
    assign base_ch = sapt_pkg::nt16_ascii(s_base_code);
    assign is_ref  = (base_ch == site_ref_reg);
    assign is_alt  = (base_ch == site_alt_reg);

    // tally cell of the kept pair
    assign row = {1'b0, pair_strand_reg[0]} + {1'b0, pair_strand_reg[1]};
    assign col = {1'b0, pair_allele_reg[0]} + {1'b0, pair_allele_reg[1]};

    // per-item state update and classification
    always_comb begin
        site_position_next = site_position_reg;
        site_ref_next      = site_ref_reg;
        site_alt_next      = site_alt_reg;
        read_ok_next       = read_ok_reg;
        read_reverse_next  = read_reverse_reg;
        walk_ref_next      = walk_ref_reg;
        walk_query_next    = walk_query_reg;
        site_found_next    = site_found_reg;
        walk_over_next     = walk_over_reg;
        kept_next          = kept_reg;
        pair_strand_next   = pair_strand_reg;
        pair_allele_next   = pair_allele_reg;
        push_entry         = '0;
        push_entry.op      = sapt_pkg::OP_PASS;

        unique case (s_mode)
            sapt_pkg::MODE_SITE_BEGIN: begin
                site_position_next = s_position;
                site_ref_next      = s_ref_letter;
                site_alt_next      = s_alt_letter;
                kept_next          = 2'd0;
                read_ok_next       = 1'b0;
                site_found_next    = 1'b0;
                walk_over_next     = 1'b0;
            end
            sapt_pkg::MODE_READ_BEGIN: begin
                read_ok_next      = ((s_read_flags & cfg.reject_flag_mask) == 16'd0) &&
                                    (s_map_quality >= cfg.min_map_quality);
                read_reverse_next = s_read_flags[sapt_pkg::FLAG_REVERSE_BIT];
                walk_ref_next     = {1'b0, s_position};
                walk_query_next   = 32'd0;
                site_found_next   = 1'b0;
                walk_over_next    = 1'b0;
            end
            sapt_pkg::MODE_CIGAR_OP: begin
                if (read_ok_reg && !site_found_reg && !walk_over_reg) begin
                    if (is_match) begin
                        if (hit) begin
                            site_found_next        = 1'b1;
                            push_entry.base_needed = 1'b1;
                            push_entry.base_offset = hit_offset;
                        end else begin
                            walk_ref_next   = ref_end[31:0];
                            walk_query_next = walk_query_reg + len32;
                        end
                    end else if ((s_cigar_code == sapt_pkg::CIGAR_D) ||
                                 (s_cigar_code == sapt_pkg::CIGAR_N)) begin
                        walk_ref_next = ref_end[31:0];
                    end else if ((s_cigar_code == sapt_pkg::CIGAR_I) ||
                                 (s_cigar_code == sapt_pkg::CIGAR_S)) begin
                        walk_query_next = walk_query_reg + len32;
                    end
                    if (!site_found_next && (walk_ref_next > site32)) begin
                        walk_over_next = 1'b1;
                    end
                end
            end
            sapt_pkg::MODE_READ_BASE: begin
                if (read_ok_reg && site_found_reg) begin
                    if (is_ref || is_alt) begin
                        if (kept_reg < 2'd2) begin
                            pair_strand_next[kept_reg[0]] = read_reverse_reg;
                            pair_allele_next[kept_reg[0]] = !is_ref;
                        end
                        if (kept_reg != 2'd3) begin
                            kept_next = kept_reg + 2'd1;
                        end
                        push_entry.read_kept = 1'b1;
                    end
                    read_ok_next = 1'b0;
                end
            end
            sapt_pkg::MODE_SITE_END: begin
                if (kept_reg == 2'd2) begin
                    push_entry.op           = sapt_pkg::OP_INCR;
                    push_entry.site_counted = 1'b1;
                    push_entry.tally_sel    = sapt_pkg::CELL_W'({1'b0, row, 1'b0} +
                                                                {2'b00, row} + {2'b00, col});
                end
                kept_next = 2'd0;
            end
            sapt_pkg::MODE_QUERY: begin
                push_entry.op        = sapt_pkg::OP_QUERY;
                push_entry.tally_sel = s_cell_index;
            end
            default: begin
                push_entry.op = sapt_pkg::OP_PASS;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            site_position_reg <= '0;
            site_ref_reg      <= '0;
            site_alt_reg      <= '0;
            read_ok_reg       <= 1'b0;
            read_reverse_reg  <= 1'b0;
            walk_ref_reg      <= '0;
            walk_query_reg    <= '0;
            site_found_reg    <= 1'b0;
            walk_over_reg     <= 1'b0;
            kept_reg          <= '0;
            pair_strand_reg   <= '0;
            pair_allele_reg   <= '0;
        end else if (accept) begin
            site_position_reg <= site_position_next;
            site_ref_reg      <= site_ref_next;
            site_alt_reg      <= site_alt_next;
            read_ok_reg       <= read_ok_next;
            read_reverse_reg  <= read_reverse_next;
            walk_ref_reg      <= walk_ref_next;
            walk_query_reg    <= walk_query_next;
            site_found_reg    <= site_found_next;
            walk_over_reg     <= walk_over_next;
            kept_reg          <= kept_next;
            pair_strand_reg   <= pair_strand_next;
            pair_allele_reg   <= pair_allele_next;
        end
    end

endmodule

[rtl/sapt_queue.sv]
module sapt_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  sapt_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output sapt_pkg::queue_entry_t pop_entry,
    output logic                   empty
);

    sapt_pkg::queue_entry_t slot_reg [sapt_pkg::QUEUE_DEPTH];

    logic [sapt_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sapt_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sapt_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == sapt_pkg::QCNT_W'(sapt_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = sapt_pkg::QPTR_W'((32'(wr_ptr_reg) + 1) % sapt_pkg::QUEUE_DEPTH);
        end
        if (pop) begin
            rd_ptr_next = sapt_pkg::QPTR_W'((32'(rd_ptr_reg) + 1) % sapt_pkg::QUEUE_DEPTH);
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/sapt_back.sv]
module sapt_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   empty,
    input  sapt_pkg::queue_entry_t entry,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_base_needed,
    output logic [31:0]            m_base_offset,
    output logic                   m_read_kept,
    output logic                   m_site_counted,
    output logic [31:0]            m_count_value
);

    logic [sapt_pkg::COUNT_WIDTH-1:0] tally_reg [sapt_pkg::TALLY_CELLS];

    logic        m_valid_reg;
    logic        base_needed_reg;
    logic [31:0] base_offset_reg;
    logic        read_kept_reg;
    logic        site_counted_reg;
    logic [31:0] count_value_reg;

    logic                             cell_ok;
    logic [sapt_pkg::COUNT_WIDTH-1:0] cell_count;

    assign pop = !empty && (!m_valid_reg || m_ready);

    assign cell_ok    = (entry.tally_sel < sapt_pkg::CELL_W'(sapt_pkg::TALLY_CELLS));
    assign cell_count = cell_ok ? tally_reg[entry.tally_sel] : '0;

    // saturating counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sapt_pkg::TALLY_CELLS; i++) begin
                tally_reg[i] <= '0;
            end
        end else if (pop && (entry.op == sapt_pkg::OP_INCR) && cell_ok) begin
            if (cell_count != '1) begin
                tally_reg[entry.tally_sel] <= cell_count + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            base_needed_reg  <= entry.base_needed;
            base_offset_reg  <= entry.base_offset;
            read_kept_reg    <= entry.read_kept;
            site_counted_reg <= entry.site_counted;
            count_value_reg  <= (entry.op == sapt_pkg::OP_QUERY) ? 32'(cell_count) : 32'd0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_base_needed  = base_needed_reg;
    assign m_base_offset  = base_offset_reg;
    assign m_read_kept    = read_kept_reg;
    assign m_site_counted = site_counted_reg;
    assign m_count_value  = count_value_reg;

endmodule

[rtl/strand_allele_pair_tally.sv]
// Strand/allele pair tally. Items enter on the s_ channel, one per cycle while
// s_ready is high: site begin, read begin, cigar ops, the read base at the reported
// offset, site end and counter query. Each item returns exactly one result on the m_
// channel, in order. The front classifies an item and updates the site, read and
// walk state in the cycle it is accepted; a four-entry queue then feeds the counter
// back end, which updates or reads one of nine saturating counters and loads the
// output register. Sustained rate is one item per cycle while m_ready is high, and
// the input stalls once four results wait in the queue behind a held output. The
// counters clear at reset; the user writes min_map_quality (byte address 0) and
// reject_flag_mask (byte address 4) over the APB port only while the block is idle;
// the block does not enforce this.
module strand_allele_pair_tally (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [30:0] s_position,
    input  logic [7:0]  s_ref_letter,
    input  logic [7:0]  s_alt_letter,
    input  logic [15:0] s_read_flags,
    input  logic [7:0]  s_map_quality,
    input  logic [3:0]  s_cigar_code,
    input  logic [27:0] s_cigar_length,
    input  logic [3:0]  s_base_code,
    input  logic [3:0]  s_cell_index,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_base_needed,
    output logic [31:0] m_base_offset,
    output logic        m_read_kept,
    output logic        m_site_counted,
    output logic [31:0] m_count_value
);

    sapt_pkg::cfg_t         cfg_reg;
    sapt_pkg::queue_entry_t push_entry;
    sapt_pkg::queue_entry_t pop_entry;

    logic cfg_write;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    // register writes
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_map_quality  <= sapt_pkg::MIN_MAPQ_RESET;
            cfg_reg.reject_flag_mask <= sapt_pkg::REJECT_MASK_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == sapt_pkg::REG_MIN_MAPQ) begin
                cfg_reg.min_map_quality <= pwdata[7:0];
            end else begin
                cfg_reg.reject_flag_mask <= pwdata[15:0];
            end
        end
    end

    // register reads
    always_comb begin
        if (paddr[2] == sapt_pkg::REG_REJECT_MASK) begin
            prdata = {16'd0, cfg_reg.reject_flag_mask};
        end else begin
            prdata = {24'd0, cfg_reg.min_map_quality};
        end
    end

    sapt_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .queue_full     (queue_full),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_position     (s_position),
        .s_ref_letter   (s_ref_letter),
        .s_alt_letter   (s_alt_letter),
        .s_read_flags   (s_read_flags),
        .s_map_quality  (s_map_quality),
        .s_cigar_code   (s_cigar_code),
        .s_cigar_length (s_cigar_length),
        .s_base_code    (s_base_code),
        .s_cell_index   (s_cell_index),
        .push           (push),
        .push_entry     (push_entry)
    );

    sapt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty)
    );

    sapt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .empty          (queue_empty),
        .entry          (pop_entry),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_base_needed  (m_base_needed),
        .m_base_offset  (m_base_offset),
        .m_read_kept    (m_read_kept),
        .m_site_counted (m_site_counted),
        .m_count_value  (m_count_value)
    );

endmodule
